@@ rtl/fvn_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Fractal value noise package
// Shared constants and the normalisation table.
// ----------------------------------------------------------------------------
package fvn_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int MAX_OCTAVES = 8;
   localparam int OUT_BITS    = 18;
   localparam int NORM_SHIFT  = 29 + MAX_OCTAVES;

   localparam logic [31:0] HASH_X    = 32'd374761393;
   localparam logic [31:0] HASH_Z    = 32'd668265263;
   localparam logic [31:0] HASH_S    = 32'd2246822519;
   localparam logic [31:0] HASH_M    = 32'd1274126177;
   localparam logic [31:0] SEED_STEP = 32'd1013;

   localparam logic CSR_SEED  = 1'b0;
   localparam logic CSR_COUNT = 1'b1;

   function automatic logic [30:0] recip(input logic [3:0] cnt);
      logic [30:0] r;
      case (cnt)
         4'd2:    r = 31'd715827883;
         4'd3:    r = 31'd613566757;
         4'd4:    r = 31'd572662306;
         4'd5:    r = 31'd554189329;
         4'd6:    r = 31'd545392673;
         4'd7:    r = 31'd541098242;
         4'd8:    r = 31'd538976288;
         default: r = 31'd1073741824;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

@@ rtl/fvn_octave.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Fractal value noise octave lane
// Four-stage lane: lattice hash of four corners, smoothstep and bilinear blend.
// ----------------------------------------------------------------------------
module fvn_octave (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic [2:0]         octave,
   input  wire logic [31:0]        seed,
   input  wire logic [31:0]        coord_x,
   input  wire logic [31:0]        coord_z,
   output logic signed [17:0]      noise
);
   import fvn_pkg::*;

   logic [63:0] sx, sz;
   logic [31:0] seed_o;
   logic [31:0] prod_tx, prod_tz;

   logic [31:0] ax_ff, bz_ff, cs_ff;
   logic [15:0] tx_ff, tz_ff, t2x_ff, t2z_ff;

   logic [31:0] hm_in [4];
   logic [31:0] hm_ff [4];
   logic [16:0] wx_in, wz_in, wx_ff, wz_ff, wz2_ff;

   logic signed [17:0] cv [4];
   logic signed [17:0] a_in, b_in, a_ff, b_ff;
   logic signed [17:0] noise_in, noise_ff;

   function automatic logic [16:0] smooth(input logic [15:0] t2, input logic [15:0] t);
      logic [17:0] f;
      logic [33:0] p;
      f = 18'(3 << FRAC_BITS) - {1'b0, t, 1'b0};
      p = 34'(t2) * 34'(f);
      return p[32:16];
   endfunction

   function automatic logic signed [17:0] lerp(input logic signed [17:0] p,
                                               input logic signed [17:0] q,
                                               input logic [16:0] w);
      logic signed [18:0] d;
      logic signed [36:0] m;
      logic signed [36:0] s;
      d = 19'(q) - 19'(p);
      m = 37'(d) * 37'(signed'({1'b0, w}));
      s = m >>> FRAC_BITS;
      return 18'(37'(p) + s);
   endfunction

   always_comb begin
      sx      = {{32{coord_x[31]}}, coord_x} << octave;
      sz      = {{32{coord_z[31]}}, coord_z} << octave;
      seed_o  = seed + 32'(octave) * SEED_STEP;
      prod_tx = 32'(sx[15:0]) * 32'(sx[15:0]);
      prod_tz = 32'(sz[15:0]) * 32'(sz[15:0]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ax_ff  <= sx[47:16] * HASH_X;
         bz_ff  <= sz[47:16] * HASH_Z;
         cs_ff  <= seed_o * HASH_S;
         tx_ff  <= sx[15:0];
         tz_ff  <= sz[15:0];
         t2x_ff <= prod_tx[31:16];
         t2z_ff <= prod_tz[31:16];
      end
   end

   always_comb begin
      logic [31:0] xs, zs, h0, h1;
      for (int k = 0; k < 4; k++) begin
         xs = (k % 2 == 1) ? ax_ff + HASH_X : ax_ff;
         zs = (k / 2 == 1) ? bz_ff + HASH_Z : bz_ff;
         h0 = xs ^ zs ^ cs_ff;
         h1 = h0 ^ (h0 >> 13);
         hm_in[k] = h1 * HASH_M;
      end
      wx_in = smooth(t2x_ff, tx_ff);
      wz_in = smooth(t2z_ff, tz_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hm_ff <= hm_in;
         wx_ff <= wx_in;
         wz_ff <= wz_in;
      end
   end

   always_comb begin
      logic [31:0] hf;
      for (int k = 0; k < 4; k++) begin
         hf    = hm_ff[k] ^ (hm_ff[k] >> 16);
         cv[k] = signed'({1'b0, hf[31:15]}) - 18'sd65536;
      end
      a_in = lerp(cv[0], cv[1], wx_ff);
      b_in = lerp(cv[2], cv[3], wx_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff   <= a_in;
         b_ff   <= b_in;
         wz2_ff <= wz_ff;
      end
   end

   assign noise_in = lerp(a_ff, b_ff, wz2_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         noise_ff <= noise_in;
      end
   end

   assign noise = noise_ff;

endmodule
`default_nettype wire

@@ rtl/fractal_value_noise.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Fractal value noise
// Pipelined fBm value noise over up to eight octaves with normalisation.
// ----------------------------------------------------------------------------
// One coordinate pair is taken per cycle and each request gives one result
// after the lane stages and the accumulate, multiply and output registers;
// the eight octave lanes run side by side, so the rate does not depend on the
// octave count. The whole pipeline holds while a result waits to be taken.
// Configuration should be written only while the block is empty.
module fractal_value_noise (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_coord_x,
   input  wire logic [31:0] req_coord_z,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [17:0]      rsp_noise_value,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_wdata
);
   import fvn_pkg::*;

   logic [31:0] seed_ff;
   logic [3:0]  count_ff;
   logic [3:0]  cnt;
   logic [6:0]  v_ff;
   logic        adv;

   logic signed [17:0] oct_noise [MAX_OCTAVES];
   logic signed [25:0] acc_in, acc_ff;
   logic [30:0]        rec_ff;
   logic signed [57:0] prod_ff;
   logic signed [57:0] rnd;
   logic signed [20:0] q;
   logic [17:0]        out_in, out_ff;

   assign csr_ready = 1'b1;
   assign adv       = !v_ff[6] || rsp_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff  <= '0;
         count_ff <= 4'd5;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SEED:  seed_ff  <= csr_wdata;
            CSR_COUNT: count_ff <= csr_wdata[3:0];
            default:   ;
         endcase
      end
   end

   always_comb begin
      if (count_ff == 4'd0) begin
         cnt = 4'd1;
      end else if (count_ff > 4'(MAX_OCTAVES)) begin
         cnt = 4'(MAX_OCTAVES);
      end else begin
         cnt = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[5:0], req_valid};
      end
   end

   for (genvar o = 0; o < MAX_OCTAVES; o++) begin : g_lane
      fvn_octave u_octave (
         .clock   (clock),
         .en      (adv),
         .octave  (3'(o)),
         .seed    (seed_ff),
         .coord_x (req_coord_x),
         .coord_z (req_coord_z),
         .noise   (oct_noise[o])
      );
   end

   always_comb begin
      acc_in = '0;
      for (int o = 0; o < MAX_OCTAVES; o++) begin
         if (4'(o) < cnt) begin
            acc_in = acc_in + (26'(oct_noise[o]) <<< (MAX_OCTAVES - 1 - o));
         end
      end
   end

   always_comb begin
      rnd = prod_ff + (58'sd1 <<< (NORM_SHIFT - 1));
      q   = 21'(rnd >>> NORM_SHIFT);
      if (q > 21'sd65536) begin
         out_in = 18'(21'sd65536);
      end else if (q < -21'sd65536) begin
         out_in = 18'(-21'sd65536);
      end else begin
         out_in = q[17:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         acc_ff  <= acc_in;
         rec_ff  <= recip(cnt);
         prod_ff <= 58'(acc_ff) * 58'(signed'({1'b0, rec_ff}));
         out_ff  <= out_in;
      end
   end

   assign rsp_valid       = v_ff[6];
   assign rsp_noise_value = out_ff;

endmodule
`default_nettype wire

@@ tb/tb_fractal_value_noise.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fractal value noise testbench
// Drives coordinate requests into the noise pipeline under random burst and
// stall patterns, predicts every noise value from a bit-exact fBm model with
// its own copy of the seed and octave count, and checks results in order.
// ----------------------------------------------------------------------------
module tb_fractal_value_noise;
   import fvn_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] z;
   } coord_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_coord_x = '0;
   logic [31:0] req_coord_z = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [17:0] rsp_noise_value;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = CSR_SEED;
   logic [31:0] csr_wdata = '0;

   coord_type   coord_pending_q[$];
   logic [17:0] noise_expect_q[$];
   logic [31:0] seed_cfg = '0;
   logic [3:0]  count_cfg = 4'd5;
   int          error_count = 0;
   int          result_count = 0;
   int          setting_count = 0;
   int          cycle_count = 0;
   int          gap_max = 6;
   int          hold_requests = 0;
   int          holds_served = 0;

   fractal_value_noise uut (.*);

   always #5 clock = ~clock;

   function automatic longint lattice_value(logic [31:0] cx, logic [31:0] cz,
                                            logic [31:0] s);
      logic [31:0] h;
      h = (cx * HASH_X) ^ (cz * HASH_Z) ^ (s * HASH_S);
      h = h ^ (h >> 13);
      h = h * HASH_M;
      h = h ^ (h >> 16);
      return longint'(h >> 15) - 65536;
   endfunction

   function automatic longint smooth(longint t);
      longint t2;
      t2 = (t * t) >>> 16;
      return (t2 * (3 * 65536 - 2 * t)) >>> 16;
   endfunction

   function automatic longint lerp16(longint p, longint q, longint w);
      return p + (((q - p) * w) >>> 16);
   endfunction

   function automatic longint norm_recip(int c);
      case (c)
         2: return 715827883;
         3: return 613566757;
         4: return 572662306;
         5: return 554189329;
         6: return 545392673;
         7: return 541098242;
         8: return 538976288;
         default: return 1073741824;
      endcase
   endfunction

   function automatic logic [17:0] fbm_noise(logic [31:0] x, logic [31:0] z,
                                             logic [31:0] seed, logic [3:0] cnt);
      int          octaves;
      logic [63:0] ux, uz;
      logic [31:0] ix, iz, s;
      longint      wx, wz, a, b, acc, v;
      octaves = (cnt == 0) ? 1 : (cnt > MAX_OCTAVES) ? MAX_OCTAVES : int'(cnt);
      acc = 0;
      for (int o = 0; o < octaves; o++) begin
         ux = {{32{x[31]}}, x} << o;
         uz = {{32{z[31]}}, z} << o;
         ix = ux[47:16];
         iz = uz[47:16];
         wx = smooth(longint'(ux[15:0]));
         wz = smooth(longint'(uz[15:0]));
         s = seed + 32'(o) * SEED_STEP;
         a = lerp16(lattice_value(ix, iz, s), lattice_value(ix + 1, iz, s), wx);
         b = lerp16(lattice_value(ix, iz + 1, s), lattice_value(ix + 1, iz + 1, s), wx);
         acc += lerp16(a, b, wz) <<< (MAX_OCTAVES - 1 - o);
      end
      v = (acc * norm_recip(octaves) + (longint'(1) <<< (NORM_SHIFT - 1))) >>> NORM_SHIFT;
      if (v > 65536) v = 65536;
      if (v < -65536) v = -65536;
      return v[17:0];
   endfunction

   // Request driver: bursts of random length separated by random gaps.
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      coord_type c;
      logic      next_valid;
      cycle_count <= cycle_count + 1;
      next_valid = req_valid;
      if (!reset) begin
         if (req_valid && req_ready) begin
            noise_expect_q.push_back(fbm_noise(req_coord_x, req_coord_z,
                                               seed_cfg, count_cfg));
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (coord_pending_q.size() > 0) begin
               c = coord_pending_q.pop_front();
               req_coord_x <= c.x;
               req_coord_z <= c.z;
               next_valid = 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(30, 1);
                  gap_left = $urandom_range(gap_max, 0);
               end
            end
         end
      end
      req_valid <= next_valid;
   end

   // Result monitor with its own stall pattern and long hold-offs on request.
   int hold_left = 0;
   int stall_mode = 0;
   always @(posedge clock) begin
      logic [17:0] want;
      logic        next_ready;
      if (!reset && rsp_valid && rsp_ready) begin
         result_count++;
         if (noise_expect_q.size() == 0) begin
            $error("unexpected result noise_value=%h", rsp_noise_value);
            error_count++;
         end else begin
            want = noise_expect_q.pop_front();
            if (want !== rsp_noise_value) begin
               $error("noise_value expected %h actual %h", want, rsp_noise_value);
               error_count++;
            end
         end
      end
      if (cycle_count % 80 == 0) stall_mode = $urandom_range(2, 0);
      if (hold_left == 0 && holds_served < hold_requests) begin
         holds_served++;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         next_ready = 1'b0;
      end else begin
         case (stall_mode)
            0: next_ready = 1'b1;
            1: next_ready = ($urandom_range(2, 0) != 0);
            default: next_ready = (cycle_count % 7) > 2;
         endcase
      end
      rsp_ready <= next_ready;
   end

   always @(posedge clock) begin
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb_fractal_value_noise: errors");
         $finish;
      end
   end

   task automatic push_coord(logic [31:0] x, logic [31:0] z);
      coord_pending_q.push_back('{x: x, z: z});
   endtask

   task automatic wait_empty();
      do @(negedge clock);
      while (coord_pending_q.size() > 0 || req_valid || noise_expect_q.size() > 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [31:0] data);
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
      if (idx == CSR_SEED) seed_cfg = data;
      else count_cfg = data[3:0];
   endtask

   task automatic random_coords(int n);
      logic [31:0] x, z;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(3, 0))
            0: begin x = $urandom(); z = $urandom(); end
            1: begin
               x = $urandom_range(2 * 65536 * 40, 0) - 65536 * 40;
               z = $urandom_range(2 * 65536 * 40, 0) - 65536 * 40;
            end
            2: begin
               x = {16'($urandom_range(65535, 0)), 16'hFFFF};
               z = {16'($urandom_range(65535, 0)), 16'h0000};
            end
            default: begin x = $urandom() | 32'h7FFF0000; z = $urandom() & 32'h8000FFFF; end
         endcase
         push_coord(x, z);
      end
   endtask

   initial begin
      logic [31:0] seeds[8];
      logic [3:0]  counts[8];
      seeds  = '{32'h0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF,
                 32'h12345678, 32'h7FFFFE00, 32'hDEADBEEF, 32'h00000001};
      counts = '{4'd5, 4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd9, 4'd7};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed requests at reset settings, then with eight octaves.
      push_coord(32'h0, 32'h0);
      push_coord(32'h7FFFFFFF, 32'h7FFFFFFF);
      push_coord(32'h80000000, 32'h80000000);
      push_coord(32'hFFFFFFFF, 32'h00000001);
      push_coord(32'h0000FFFF, 32'hFFFF0000);
      push_coord(32'hFFFF0000, 32'h0000FFFF);
      push_coord(32'h7FFF8000, 32'h80008000);
      wait_empty();
      write_reg(CSR_COUNT, 32'hFFFFFFF8);
      write_reg(CSR_SEED, 32'h7FFFFFFF);
      setting_count++;
      push_coord(32'h7FFFFFFF, 32'h80000000);
      push_coord(32'h7FFF0000, 32'hFFFFFFFF);
      push_coord(32'h00008000, 32'h00004000);
      push_coord(32'h80000000, 32'h7FFFFFFF);
      wait_empty();

      for (int p = 0; p < 8; p++) begin
         write_reg(CSR_SEED, seeds[p]);
         write_reg(CSR_COUNT, {28'h0, counts[p]});
         setting_count++;
         gap_max = (p % 3 == 0) ? 0 : 8;
         if (p == 2) begin
            hold_requests++;
            random_coords(110);
            wait_empty();
            continue;
         end
         random_coords(55);
         // Pause the requests until everything issued so far has come back.
         if (p == 5) wait_empty();
         random_coords(55);
         wait_empty();
      end

      if (noise_expect_q.size() != 0) begin
         $error("%0d noise values never arrived", noise_expect_q.size());
         error_count++;
      end
      $display("Checked %0d noise values over %0d seed and octave settings,",
               result_count, setting_count + 1);
      $display("including octave clamping, seed wrap and lattice wrap at the extremes.");
      if (error_count == 0) begin
         $display("tb_fractal_value_noise: clean");
      end else begin
         $display("tb_fractal_value_noise: errors");
      end
      $finish;
   end

endmodule
